@@ rtl/distance_vector_route_table_assert.svh @@
// Assertion macros shared by the route table RTL.
// Expects signals named clk and rst in the scope of use.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// same-cycle implication
`define DVRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table assertion failed");

// next-cycle implication
`define DVRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table assertion failed");

`endif

@@ rtl/dvrt_pkg.sv @@
// Shared types, widths and helpers for the route table.
// No dependencies.
package dvrt_pkg;

  localparam int NODES_DEFAULT = 16;
  localparam int CMD_W         = 2;
  localparam int NODE_W        = 4;
  localparam int DIST_W        = 8;
  localparam int HOP_W         = 4;
  localparam int COUNT_W       = 5;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;
  localparam int QDEPTH        = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LINK  = 2'd1,
    CMD_EXCH  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LINK,
    OP_EXCH,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [COUNT_W-1:0]  n;
  } op_t;

  typedef struct packed {
    logic               known;
    logic [DIST_W-1:0]  metric;
    logic [HOP_W-1:0]   hop;
  } route_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] d);
    return (d == {DIST_W{1'b1}}) ? d : d + 1'b1;
  endfunction

endpackage

@@ rtl/dvrt_if.sv @@
// Channel interfaces: command items in, result items out, config writes.
// Depends on dvrt_pkg.
interface dvrt_cmd_if import dvrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source(output valid, command, node_a, node_b, input ready);
  modport sink(input valid, command, node_a, node_b, output ready);
endinterface

interface dvrt_rsp_if import dvrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              known;
  logic [DIST_W-1:0] distance;
  logic [HOP_W-1:0]  next_hop;
  modport source(output valid, known, distance, next_hop, input ready);
  modport sink(input valid, known, distance, next_hop, output ready);
endinterface

interface dvrt_cfg_if import dvrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] node_count;
  modport source(output valid, node_count, input ready);
  modport sink(input valid, node_count, output ready);
endinterface

@@ rtl/distance_vector_route_table.sv @@
// Route table top level: front end, op queue, back end.
// Depends on dvrt_pkg, dvrt_if, dvrt_front, dvrt_queue, dvrt_back.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   command, node_a, node_b
//   rsp      out  valid/ready   known, distance, next_hop
//   cfg      in   valid/ready   node_count (always ready)
//
// After reset the table is swept to identity, with cmd held off.
// The back end takes one queued item at a time; an exchange walks
// one destination per cycle over two mirrored RAMs, and a clear re-sweeps the table.
// A 2-entry op queue keeps cmd taking items while rsp is stalled.
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dvrt_cmd_if.sink   cmd,
  dvrt_cfg_if.sink   cfg,
  dvrt_rsp_if.source rsp
);

  logic    push;
  op_t     push_op;
  logic    pop;
  op_t     pop_op;
  q_stat_t qs;
  logic    booting;

  dvrt_front #(.NODES(NODES)) u_front (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .booting(booting),
    .qs(qs), .push(push), .push_op(push_op)
  );

  dvrt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_op(push_op),
    .pop(pop), .pop_op(pop_op), .stat(qs)
  );

  dvrt_back #(.NODES(NODES)) u_back (
    .clk(clk), .rst(rst), .qs(qs), .pop_op(pop_op), .pop(pop),
    .booting(booting), .rsp(rsp)
  );

endmodule

@@ rtl/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dvrt_queue.sv @@
// Short op queue between the front and back ends.
// Depends on dvrt_pkg and the assertion macros.
`include "distance_vector_route_table_assert.svh"
module dvrt_queue import dvrt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     pop_op,
  output q_stat_t stat
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  op_t              slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DVRT_ASSERT_IMP(a_no_overflow, push, !stat.full || pop)
  `DVRT_ASSERT_IMP(a_no_underflow, pop, !stat.empty)

endmodule

@@ rtl/dvrt_front.sv @@
// Front end: takes command items and config writes, range-checks and
// classifies each item into a queue op. Depends on dvrt_pkg and dvrt_if.
module dvrt_front import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  dvrt_cmd_if.sink         cmd,
  dvrt_cfg_if.sink         cfg,
  input  logic             booting,
  input  q_stat_t          qs,
  output logic             push,
  output op_t              push_op
);

  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] active_n;
  logic               in_range;
  logic               distinct;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg.valid) begin
      node_count <= cfg.node_count;
    end
  end

  assign cfg.ready = 1'b1;
  assign cmd.ready = !qs.full && !booting;
  assign push      = cmd.valid && cmd.ready;

  assign active_n = (32'(node_count) < NODES) ? node_count : COUNT_W'(NODES);
  assign in_range = ({1'b0, cmd.node_a} < active_n) && ({1'b0, cmd.node_b} < active_n);
  assign distinct = (cmd.node_a != cmd.node_b);

  always_comb begin
    push_op.a = cmd.node_a;
    push_op.b = cmd.node_b;
    push_op.n = active_n;
    unique case (cmd_t'(cmd.command))
      CMD_CLEAR: push_op.kind = OP_CLEAR;
      CMD_LINK:  push_op.kind = (in_range && distinct) ? OP_LINK : OP_NOP;
      CMD_EXCH:  push_op.kind = (in_range && distinct) ? OP_EXCH : OP_NOP;
      CMD_READ:  push_op.kind = in_range ? OP_READ : OP_NOP;
      default:   push_op.kind = OP_NOP;
    endcase
  end

endmodule

@@ rtl/dvrt_back.sv @@
// Back end: executes queued ops on two mirrored copies of the route table
// and holds the result register. Depends on dvrt_pkg, dvrt_if, dvrt_ram.
`include "distance_vector_route_table_assert.svh"
module dvrt_back import dvrt_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  q_stat_t   qs,
  input  op_t       pop_op,
  output logic      pop,
  output logic      booting,
  dvrt_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_LINK, S_READ, S_EXCH} state_t;

  state_t             state;
  logic               clr_resp;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [NODE_W-1:0]  ra;
  logic [NODE_W-1:0]  rb;
  logic [COUNT_W-1:0] n_reg;
  logic [COUNT_W-1:0] jc;
  logic               pend;
  logic [IDX_W-1:0]   pend_j;
  logic               res_valid;
  route_t             res;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  route_t             wdata;
  logic [ADDR_W-1:0]  raddr_x;
  logic [ADDR_W-1:0]  raddr_y;
  route_t             rd_x;
  route_t             rd_y;
  logic               slot_free;
  logic               issue;
  logic [IDX_W-1:0]   col_j;
  logic               rule1;
  logic               rule2;
  logic [IDX_W-1:0]   wr_row;

  function automatic logic [IDX_W-1:0] idx(input logic [NODE_W-1:0] v);
    return IDX_W'(v);
  endfunction

  dvrt_ram #(.WIDTH($bits(route_t)), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr_x), .rdata(rd_x)
  );

  dvrt_ram #(.WIDTH($bits(route_t)), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr_y), .rdata(rd_y)
  );

  assign slot_free = !res_valid || rsp.ready;
  assign pop       = (state == S_IDLE) && !qs.empty && slot_free;
  assign col_j     = IDX_W'(jc[NODE_W-1:0]);
  assign issue     = (state == S_EXCH) && (jc < n_reg);
  assign wr_row    = waddr[ADDR_W-1 -: IDX_W];

  // rx unknown, ry known: x learns via y
  assign rule1 = !rd_x.known && rd_y.known;
  // both known, hops differ, x shorter: y corrects via x
  assign rule2 = rd_x.known && rd_y.known && (rd_x.hop != rd_y.hop) &&
                 (rd_x.metric < rd_y.metric);

  assign rsp.valid    = res_valid;
  assign rsp.known    = res.known;
  assign rsp.distance = res.metric;
  assign rsp.next_hop = res.hop;
  assign booting      = (state == S_INIT) && !clr_resp;

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_x = {idx(ra), col_j};
    raddr_y = {idx(rb), col_j};
    unique case (state)
      S_INIT: begin
        we          = 1'b1;
        waddr       = {row, col};
        wdata.known = (row == col);
        wdata.hop   = (row == col) ? HOP_W'(col) : '0;
      end
      S_IDLE: begin
        raddr_x = {idx(pop_op.a), idx(pop_op.b)};
        if (pop && (pop_op.kind == OP_LINK)) begin
          we    = 1'b1;
          waddr = {idx(pop_op.a), idx(pop_op.b)};
          wdata = '{known: 1'b1, metric: DIST_W'(1), hop: pop_op.b};
        end
      end
      S_LINK: begin
        we    = 1'b1;
        waddr = {idx(rb), idx(ra)};
        wdata = '{known: 1'b1, metric: DIST_W'(1), hop: ra};
      end
      S_EXCH: begin
        if (pend && rule1) begin
          we    = 1'b1;
          waddr = {idx(ra), pend_j};
          wdata = '{known: 1'b1, metric: inc_sat(rd_y.metric), hop: rb};
        end else if (pend && rule2) begin
          we    = 1'b1;
          waddr = {idx(rb), pend_j};
          wdata = '{known: 1'b1, metric: inc_sat(rd_x.metric), hop: ra};
        end
      end
      S_READ: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_resp  <= 1'b0;
      row       <= '0;
      col       <= '0;
      jc        <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (col == LAST) begin
            col <= '0;
            if (row == LAST) begin
              row   <= '0;
              state <= S_IDLE;
              if (clr_resp) begin
                res_valid <= 1'b1;
                res       <= '0;
              end
              clr_resp <= 1'b0;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_IDLE: begin
          if (pop) begin
            ra <= pop_op.a;
            rb <= pop_op.b;
            unique case (pop_op.kind)
              OP_NOP: begin
                res_valid <= 1'b1;
                res       <= '0;
              end
              OP_CLEAR: begin
                clr_resp <= 1'b1;
                state    <= S_INIT;
              end
              OP_LINK: state <= S_LINK;
              OP_EXCH: begin
                n_reg <= pop_op.n;
                jc    <= '0;
                pend  <= 1'b0;
                state <= S_EXCH;
              end
              OP_READ: state <= S_READ;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LINK: begin
          res_valid <= 1'b1;
          res       <= '0;
          state     <= S_IDLE;
        end
        S_READ: begin
          res_valid <= 1'b1;
          res       <= rd_x.known ? rd_x : '0;
          state     <= S_IDLE;
        end
        S_EXCH: begin
          pend   <= issue;
          pend_j <= col_j;
          if (issue) begin
            jc <= jc + 1'b1;
          end
          if (!issue && !pend) begin
            res_valid <= 1'b1;
            res       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DVRT_ASSERT_IMP(a_exch_rows, (state == S_EXCH) && we, (wr_row == idx(ra)) || (wr_row == idx(rb)))
  `DVRT_ASSERT_IMP(a_one_rule, (state == S_EXCH) && pend, !(rule1 && rule2))
  `DVRT_ASSERT_NEXT(a_read_result, state == S_READ, res_valid)

endmodule
